[hw/rtl/top_k_score_list_top_defines.svh]
// Assertion macros for the top-k score list.
// Used by top_k_score_list_top; relies on clk and rst_n in the including scope.
`ifndef TOP_K_SCORE_LIST_TOP_DEFINES_SVH
`define TOP_K_SCORE_LIST_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TKSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TKSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tksl_pkg.sv]
// Shared types and constants for the top-k score list.
// No dependencies; used by tksl_engine, top_k_score_list_top and the testbench.
`default_nettype none

package tksl_pkg;

    // Built capacity of the rank memory
    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths
    localparam int ID_W    = 32;
    localparam int SCORE_W = 16;
    localparam int KEEP_W  = 5;
    localparam int FILL_W  = 5;
    localparam int POS_W   = 4;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    // Item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_REPLACED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDATA,
        S_CHECK,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    // One rank entry as stored in memory
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Memory access issued by the engine each cycle
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_cmd_t;

    // Finished result handed to the output register
    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [FILL_W-1:0]  fill;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/tksl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tksl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/tksl_engine.sv]
// Sequencer for the top-k score list: reads, shifts and writes rank entries.
// Depends on tksl_pkg; drives the rank RAM through a mem_cmd_t.
`default_nettype none

module tksl_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire logic [tksl_pkg::ID_W-1:0]     item_id,
    input  wire logic [tksl_pkg::SCORE_W-1:0]  item_score,
    input  wire logic [tksl_pkg::POS_W-1:0]    position,
    input  wire logic [tksl_pkg::KEEP_W-1:0]   keep_count,
    output tksl_pkg::mem_cmd_t                 mem_cmd,
    input  wire tksl_pkg::entry_t              rd_entry,
    input  wire logic                          out_free,
    output logic                               done,
    output tksl_pkg::result_t                  result
);

    localparam int ADDR_W = tksl_pkg::ADDR_W;
    localparam int CNT_W  = tksl_pkg::CNT_W;

    tksl_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]              held_reg, held_next;
    logic [ADDR_W-1:0]             idx_reg, idx_next;
    logic [tksl_pkg::ID_W-1:0]     id_reg, id_next;
    logic [tksl_pkg::SCORE_W-1:0]  score_reg, score_next;
    tksl_pkg::status_t             res_status_reg, res_status_next;
    logic [tksl_pkg::ID_W-1:0]     res_id_reg, res_id_next;
    logic [tksl_pkg::SCORE_W-1:0]  res_score_reg, res_score_next;

    logic                          in_fire;
    logic [CNT_W-1:0]              limit;
    logic                          has_room;
    logic                          wins_low;
    logic                          stays;

    // Effective keep count: zero acts as one, saturate at capacity
    always_comb
    begin
        if (keep_count == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (32'(keep_count) > 32'(tksl_pkg::MAX_ENTRIES))
        begin
            limit = CNT_W'(tksl_pkg::MAX_ENTRIES);
        end
        else
        begin
            limit = CNT_W'(keep_count);
        end
    end

    assign in_stall = (state_reg != tksl_pkg::S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign has_room = (held_reg < limit);
    assign wins_low = (score_reg > rd_entry.score);
    assign stays    = (rd_entry.score >= score_reg);

    // Next state and datapath registers
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        idx_next        = idx_reg;
        id_next         = id_reg;
        score_next      = score_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_score_next  = res_score_reg;
        case (state_reg)
            tksl_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    id_next        = item_id;
                    score_next     = item_score;
                    res_id_next    = '0;
                    res_score_next = '0;
                    if (kind == tksl_pkg::KIND_READ)
                    begin
                        if (32'(position) < 32'(held_reg))
                        begin
                            res_status_next = tksl_pkg::ST_READ_OK;
                            state_next      = tksl_pkg::S_RDATA;
                        end
                        else
                        begin
                            res_status_next = tksl_pkg::ST_READ_EMPTY;
                            state_next      = tksl_pkg::S_DONE;
                        end
                    end
                    else if (has_room)
                    begin
                        held_next       = held_reg + CNT_W'(1);
                        res_status_next = tksl_pkg::ST_ADDED;
                        idx_next        = ADDR_W'(held_reg);
                        if (held_reg == '0)
                        begin
                            state_next = tksl_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = tksl_pkg::S_SHIFT;
                        end
                    end
                    else
                    begin
                        idx_next   = ADDR_W'(held_reg - CNT_W'(1));
                        state_next = tksl_pkg::S_CHECK;
                    end
                end
            end
            tksl_pkg::S_RDATA:
            begin
                res_id_next    = rd_entry.id;
                res_score_next = rd_entry.score;
                state_next     = tksl_pkg::S_DONE;
            end
            tksl_pkg::S_CHECK:
            begin
                if (wins_low)
                begin
                    res_status_next = tksl_pkg::ST_REPLACED;
                    if (idx_reg == '0)
                    begin
                        state_next = tksl_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = tksl_pkg::S_SHIFT;
                    end
                end
                else
                begin
                    res_status_next = tksl_pkg::ST_DROPPED;
                    state_next      = tksl_pkg::S_DONE;
                end
            end
            tksl_pkg::S_SHIFT:
            begin
                if (stays)
                begin
                    state_next = tksl_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg - ADDR_W'(1);
                    if (idx_reg == ADDR_W'(1))
                    begin
                        state_next = tksl_pkg::S_PLACE;
                    end
                end
            end
            tksl_pkg::S_PLACE:
            begin
                state_next = tksl_pkg::S_DONE;
            end
            tksl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = tksl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tksl_pkg::S_IDLE;
            end
        endcase
    end

    // Memory commands and handoff
    always_comb
    begin
        mem_cmd.wr_en         = 1'b0;
        mem_cmd.wr_addr       = idx_reg;
        mem_cmd.wr_data.id    = id_reg;
        mem_cmd.wr_data.score = score_reg;
        mem_cmd.rd_addr       = idx_reg - ADDR_W'(1);
        done                  = 1'b0;
        case (state_reg)
            tksl_pkg::S_IDLE:
            begin
                if (kind == tksl_pkg::KIND_READ)
                begin
                    mem_cmd.rd_addr = ADDR_W'(position);
                end
                else
                begin
                    // lowest held rank, both for the walk and the full check
                    mem_cmd.rd_addr = ADDR_W'(held_reg - CNT_W'(1));
                    if (in_fire && has_room && held_reg == '0)
                    begin
                        mem_cmd.wr_en         = 1'b1;
                        mem_cmd.wr_addr       = '0;
                        mem_cmd.wr_data.id    = item_id;
                        mem_cmd.wr_data.score = item_score;
                    end
                end
            end
            tksl_pkg::S_CHECK:
            begin
                if (wins_low && idx_reg == '0)
                begin
                    mem_cmd.wr_en = 1'b1;
                end
            end
            tksl_pkg::S_SHIFT:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.rd_addr = idx_reg - ADDR_W'(2);
                if (!stays)
                begin
                    // move the lower-ranked entry down one slot
                    mem_cmd.wr_data = rd_entry;
                end
            end
            tksl_pkg::S_PLACE:
            begin
                mem_cmd.wr_en = 1'b1;
            end
            tksl_pkg::S_DONE:
            begin
                done = out_free;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign result.status = res_status_reg;
    assign result.id     = res_id_reg;
    assign result.score  = res_score_reg;
    assign result.fill   = tksl_pkg::FILL_W'(held_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tksl_pkg::S_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        id_reg         <= id_next;
        score_reg      <= score_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_score_reg  <= res_score_next;
    end

endmodule

`default_nettype wire

[hw/rtl/top_k_score_list_top.sv]
// Channel     Handshake             Beat contents
// ---------   -------------------   ---------------------------------------
// input       in_valid / in_stall   kind, item_id, item_score, position
// output      out_valid / out_stall status, out_id, out_score, fill_level
// config      cfg_valid / cfg_ready cfg_data (keep_count)
//
// A read of a held rank passes S_RDATA, a read past the fill goes straight to S_DONE;
// an insert into an empty list, or a full-list replace with one entry held, writes without a walk;
// other inserts and replaces shift entries down in S_SHIFT (S_PLACE writes rank 0); a full-list drop ends in S_CHECK.
// The single read and write port of the rank RAM moves one entry per cycle.
// The next input beat is taken once the result sits in the output register.
// Reset empties the list and sets keep_count to 16; RAM contents stay as is.
// Top level of the top-k score list; depends on tksl_pkg, tksl_ram,
// tksl_engine and top_k_score_list_top_defines.svh.
`default_nettype none

`include "top_k_score_list_top_defines.svh"

module top_k_score_list_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire logic [tksl_pkg::ID_W-1:0]     item_id,
    input  wire logic [tksl_pkg::SCORE_W-1:0]  item_score,
    input  wire logic [tksl_pkg::POS_W-1:0]    position,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [tksl_pkg::ID_W-1:0]          out_id,
    output logic [tksl_pkg::SCORE_W-1:0]       out_score,
    output logic [tksl_pkg::FILL_W-1:0]        fill_level,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tksl_pkg::KEEP_W-1:0]   cfg_data
);

    logic [tksl_pkg::KEEP_W-1:0]   keep_reg;
    logic                          out_valid_reg, out_valid_next;
    tksl_pkg::result_t             out_res_reg;
    tksl_pkg::mem_cmd_t            mem_cmd;
    tksl_pkg::entry_t              rd_entry;
    tksl_pkg::result_t             result;
    logic                          out_free;
    logic                          done;
    logic                          out_is_read_ok;
    logic                          out_is_insert;

    // Rank memory: one entry per rank, best score at address 0
    tksl_ram #(
        .WIDTH (tksl_pkg::ENTRY_W),
        .DEPTH (tksl_pkg::MAX_ENTRIES)
    ) u_rank_ram (
        .clk     (clk),
        .wr_en   (mem_cmd.wr_en),
        .wr_addr (mem_cmd.wr_addr),
        .wr_data (mem_cmd.wr_data),
        .rd_addr (mem_cmd.rd_addr),
        .rd_data (rd_entry)
    );

    tksl_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .item_id    (item_id),
        .item_score (item_score),
        .position   (position),
        .keep_count (keep_reg),
        .mem_cmd    (mem_cmd),
        .rd_entry   (rd_entry),
        .out_free   (out_free),
        .done       (done),
        .result     (result)
    );

    // Config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= tksl_pkg::KEEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            keep_reg <= cfg_data;
        end
    end

    // Output register
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid_next = done || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_res_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign out_id     = out_res_reg.id;
    assign out_score  = out_res_reg.score;
    assign fill_level = out_res_reg.fill;

    // Result kinds on the output, for the checks
    assign out_is_read_ok = out_valid && status == tksl_pkg::ST_READ_OK;
    assign out_is_insert  = out_valid && (status == tksl_pkg::ST_ADDED ||
                                          status == tksl_pkg::ST_REPLACED ||
                                          status == tksl_pkg::ST_DROPPED);

    // Checks
    `TKSL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept without busy")
    `TKSL_ASSERT_NOW(a_read_ok_fill, out_is_read_ok, fill_level != '0, "read ok on empty list")
    `TKSL_ASSERT_NOW(a_insert_zero_payload, out_is_insert, out_id == '0 && out_score == '0, "insert payload")

endmodule

`default_nettype wire

[test/top_k_score_list_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the top-k score list: directed table, then random inserts and reads.
// Depends on tksl_pkg and top_k_score_list_top; has its own ranked-list predictor.

module top_k_score_list_top_tb;

    import tksl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASE_ITEMS    = 210;
    localparam int N_PHASES       = 8;
    localparam int N_ROWS         = 24;

    localparam result_t NO_RESULT = '0;

    // One directed row: either a keep_count write or an item beat
    typedef struct {
        bit                 is_cfg;
        logic [KEEP_W-1:0]  cfg_val;
        logic               kind;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [POS_W-1:0]   pos;
        bit                 typed;
        result_t            want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                in_valid;
    logic                in_stall;
    logic                kind;
    logic [ID_W-1:0]     item_id;
    logic [SCORE_W-1:0]  item_score;
    logic [POS_W-1:0]    position;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          status;
    logic [ID_W-1:0]     out_id;
    logic [SCORE_W-1:0]  out_score;
    logic [FILL_W-1:0]   fill_level;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [KEEP_W-1:0]   cfg_data;

    // Predictor state: ranked list and keep_count
    logic [ID_W-1:0]     kept_ids    [MAX_ENTRIES];
    logic [SCORE_W-1:0]  kept_scores [MAX_ENTRIES];
    int                  kept_cnt = 0;
    logic [KEEP_W-1:0]   keep_reg = KEEP_RESET;

    result_t pending_results [$];

    int fail_cnt      = 0;
    int got_cnt       = 0;
    int sent_cnt      = 0;
    int idle_cycles   = 0;
    bit long_hold_req = 1'b0;

    // Stimulus table; fixed expectations only where obvious
    stim_row_t directed_rows [N_ROWS] = '{
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd0,  1'b1,
          '{ST_READ_EMPTY, 32'h0, 16'h0, 5'd0}},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd15, 1'b1,
          '{ST_READ_EMPTY, 32'h0, 16'h0, 5'd0}},
        // keep_count zero acts as one
        '{1'b1, 5'd0,  KIND_INSERT, 32'h0,        16'h0,    4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_INSERT, 32'h1,        16'h0,    4'd0,  1'b1,
          '{ST_ADDED, 32'h0, 16'h0, 5'd1}},
        // equal score on a full list is dropped
        '{1'b0, 5'd0,  KIND_INSERT, 32'hFFFFFFFF, 16'h0,    4'd15, 1'b1,
          '{ST_DROPPED, 32'h0, 16'h0, 5'd1}},
        '{1'b0, 5'd0,  KIND_INSERT, 32'hDEADBEEF, 16'h1,    4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd1,  1'b1,
          '{ST_READ_EMPTY, 32'h0, 16'h0, 5'd1}},
        // keep_count above capacity saturates
        '{1'b1, 5'd31, KIND_INSERT, 32'h0,        16'h0,    4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_INSERT, 32'hFFFFFFFF, 16'hFFFF, 4'd0,  1'b1,
          '{ST_ADDED, 32'h0, 16'h0, 5'd2}},
        '{1'b0, 5'd0,  KIND_INSERT, 32'h12345678, 16'h8000, 4'd0,  1'b0, NO_RESULT},
        // tie goes after the entry already held
        '{1'b0, 5'd0,  KIND_INSERT, 32'hA5A5A5A5, 16'h8000, 4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_INSERT, 32'h5A5A5A5A, 16'h7FFF, 4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd0,  1'b1,
          '{ST_READ_OK, 32'hFFFFFFFF, 16'hFFFF, 5'd5}},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd2,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd4,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd5,  1'b1,
          '{ST_READ_EMPTY, 32'h0, 16'h0, 5'd5}},
        // keep_count below the fill: list counts as full
        '{1'b1, 5'd2,  KIND_INSERT, 32'h0,        16'h0,    4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_INSERT, 32'h0,        16'h1,    4'd0,  1'b1,
          '{ST_DROPPED, 32'h0, 16'h0, 5'd5}},
        '{1'b0, 5'd0,  KIND_INSERT, 32'h0F0F0F0F, 16'h8000, 4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd3,  1'b0, NO_RESULT},
        '{1'b1, 5'd16, KIND_INSERT, 32'h0,        16'h0,    4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_INSERT, 32'hFFFFFFFF, 16'hFFFF, 4'd0,  1'b0, NO_RESULT},
        '{1'b0, 5'd0,  KIND_READ,   32'h0,        16'h0,    4'd15, 1'b1,
          '{ST_READ_EMPTY, 32'h0, 16'h0, 5'd6}}
    };

    top_k_score_list_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .item_id    (item_id),
        .item_score (item_score),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_id     (out_id),
        .out_score  (out_score),
        .fill_level (fill_level),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Put a pair among the first n ranks, after equal scores
    function automatic void insert_at_rank(input int n, input logic [ID_W-1:0] id,
                                           input logic [SCORE_W-1:0] score);
        int p;
        p = 0;
        while (p < n && kept_scores[p] >= score)
            p++;
        for (int i = n; i > p; i--)
        begin
            kept_ids[i]    = kept_ids[i-1];
            kept_scores[i] = kept_scores[i-1];
        end
        kept_ids[p]    = id;
        kept_scores[p] = score;
    endfunction

    // Apply one beat to the ranked list and return its result
    function automatic result_t rank_list_update(input logic k, input logic [ID_W-1:0] id,
                                                 input logic [SCORE_W-1:0] score,
                                                 input logic [POS_W-1:0] pos);
        result_t r;
        int      lim;
        r = '0;
        if (k == KIND_INSERT)
        begin
            lim = int'(keep_reg);
            if (lim == 0)
                lim = 1;
            if (lim > MAX_ENTRIES)
                lim = MAX_ENTRIES;
            if (kept_cnt < lim)
            begin
                insert_at_rank(kept_cnt, id, score);
                kept_cnt++;
                r.status = ST_ADDED;
            end
            else if (kept_cnt > 0 && score > kept_scores[kept_cnt-1])
            begin
                insert_at_rank(kept_cnt - 1, id, score);
                r.status = ST_REPLACED;
            end
            else
                r.status = ST_DROPPED;
        end
        else if (int'(pos) < kept_cnt)
        begin
            r.status = ST_READ_OK;
            r.id     = kept_ids[pos];
            r.score  = kept_scores[pos];
        end
        else
            r.status = ST_READ_EMPTY;
        r.fill = FILL_W'(kept_cnt);
        return r;
    endfunction

    // Scores aimed at the list: random, just above the lowest, near a held score, extremes
    function automatic logic [SCORE_W-1:0] pick_score();
        int sel;
        int r;
        sel = $urandom_range(0, 9);
        if (kept_cnt == 0 || sel < 4)
            return SCORE_W'($urandom);
        if (sel == 9)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        if (sel < 7)
            r = int'(kept_scores[kept_cnt-1]) + $urandom_range(1, 64);
        else
            r = int'(kept_scores[$urandom_range(0, kept_cnt - 1)]) + $urandom_range(0, 1);
        if (r > 65535)
            r = 65535;
        return SCORE_W'(r);
    endfunction

    // Offer one beat after a random gap; predict on acceptance
    task automatic send_item(input logic k, input logic [ID_W-1:0] id,
                             input logic [SCORE_W-1:0] score, input logic [POS_W-1:0] pos,
                             input bit typed, input result_t typed_res);
        int      gap;
        result_t r;
        gap = (sent_cnt % 80 < 20) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        item_id    <= id;
        item_score <= score;
        position   <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_cnt++;
        r = rank_list_update(k, id, score, pos);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // keep_count write, only with the block drained
    task automatic write_keep(input logic [KEEP_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        keep_reg = v;
    endtask

    // Result side: random stall per beat, one long hold-off on request, checking
    initial
    begin : result_monitor
        result_t want;
        int      hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got_cnt++;
                if (pending_results.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result beat: status %0d id %h score %h fill %0d",
                                 status, out_id, out_score, fill_level);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || out_id !== want.id ||
                        out_score !== want.score || fill_level !== want.fill)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $write("result mismatch (expected/actual): status %0d/%0d ",
                                   want.status, status);
                            $display("id %h/%h score %h/%h fill %0d/%0d",
                                     want.id, out_id, want.score, out_score,
                                     want.fill, fill_level);
                        end
                    end
                end
                hold = (got_cnt % 70 < 20) ? 0 : $urandom_range(0, 3);
            end
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("top_k_score_list_top_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main sequence
    initial
    begin : stimulus
        logic [KEEP_W-1:0] phase_keep [N_PHASES];
        bit                is_read;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        kind       <= KIND_INSERT;
        item_id    <= '0;
        item_score <= '0;
        position   <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        phase_keep = '{5'd3, 5'd0, 5'd9, 5'd1, 5'd12, 5'd31, 5'd17, 5'd16};
        phase_keep[4] = KEEP_W'($urandom_range(10, 15));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_keep(directed_rows[i].cfg_val);
            else
                send_item(directed_rows[i].kind, directed_rows[i].id, directed_rows[i].score,
                          directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, one keep_count setting each
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_keep(phase_keep[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == 100)
                    long_hold_req = 1'b1;
                if (ph == 4 && n == 100)
                begin
                    // sender pause until the block has drained
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
                is_read = ($urandom_range(0, 9) < 4);
                send_item(is_read ? KIND_READ : KIND_INSERT, ID_W'($urandom), pick_score(),
                          POS_W'($urandom_range(0, 15)), 1'b0, NO_RESULT);
            end
        end

        // Drain and let any stray beat show up
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_cnt == 0)
            $display("top_k_score_list_top_tb OK");
        else
            $display("top_k_score_list_top_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tksl_pkg.sv
hw/rtl/tksl_ram.sv
hw/rtl/tksl_engine.sv
hw/rtl/top_k_score_list_top.sv
test/top_k_score_list_top_tb.sv
